FILE: rtl/ppsp_pkg.sv
// ----------------------------------------------------------------------------
// ppsp_pkg: shared definitions for the path point stream parser
// Result kinds, frame status codes, register indexes and the record that
// travels from the parser front to the result back end.
// ----------------------------------------------------------------------------
package ppsp_pkg;

    // record queue depth default (range 2 to 16)
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // item byte counts
    localparam int META_BYTES        = 12;
    localparam int COUNT_BYTES       = 2;
    localparam int WORD_POINT_BYTES  = 10;
    localparam int FLOAT_POINT_BYTES = 11;

    // configuration register indexes
    localparam logic REG_FORMAT_WORDS  = 1'b0;
    localparam logic REG_FORMAT_FLOATS = 1'b1;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_META   = 2'd1,
        KIND_POINT  = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_CHECKSUM  = 2'd1,
        STATUS_TRUNCATED = 2'd2,
        STATUS_UNKNOWN   = 2'd3
    } status_t;

    // one accepted byte's worth of results: an optional item and an optional end
    typedef struct packed {
        logic        item_valid;
        kind_t       item_kind;
        logic        item_fmt;
        logic [63:0] asm_low;
        logic [31:0] asm_high;
        logic        end_valid;
        status_t     end_status;
    } record_t;

endpackage

FILE: rtl/path_point_stream_parser_top.sv
// ----------------------------------------------------------------------------
// path_point_stream_parser_top: path point stream parser
// Parses frame bytes into path headers, metas, points and a frame end beat.
//
//   channel   direction  handshake              payload
//   config    in         cfg_write_en           cfg_index, cfg_data
//   bytes     in         push / full            data_byte, final_byte, expected_sum
//   results   out        empty / pop            result_kind .. last_result
//
// One byte is taken every cycle while full is low; the parser front builds each byte's
// record combinationally. A result goes via the record queue and the back end's held
// record. A final byte that also completes an item gives two result beats, shown in
// turn by the back end; the record queue (QUEUE_DEPTH) absorbs that.
// Reset is asynchronous and takes effect at once; no clearing pass.
// A stalled result side fills the queue and then raises full.
// ----------------------------------------------------------------------------
module path_point_stream_parser_top #(
    parameter int QUEUE_DEPTH = ppsp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    input  logic [31:0] expected_sum,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  result_kind,
    output logic        path_format,
    output logic [15:0] path_points,
    output logic [63:0] meta_name,
    output logic [31:0] meta_value,
    output logic [31:0] x_word,
    output logic [31:0] y_word,
    output logic [15:0] red,
    output logic [15:0] green,
    output logic [15:0] blue,
    output logic [1:0]  frame_status,
    output logic        last_result
);
    import ppsp_pkg::*;

    record_t wr_rec;
    record_t rd_rec;
    logic    wr_en;
    logic    rd_en;
    logic    q_empty;
    logic    accept;

    assign accept = push && !full;

    // parser front
    ppsp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .data_byte    (data_byte),
        .final_byte   (final_byte),
        .expected_sum (expected_sum),
        .rec_write    (wr_en),
        .rec          (wr_rec)
    );

    // record queue
    ppsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_rec),
        .rd_en   (rd_en),
        .rd_data (rd_rec),
        .full    (full),
        .empty   (q_empty)
    );

    // result back end
    ppsp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (rd_rec),
        .q_empty      (q_empty),
        .q_read       (rd_en),
        .pop          (pop),
        .empty        (empty),
        .result_kind  (result_kind),
        .path_format  (path_format),
        .path_points  (path_points),
        .meta_name    (meta_name),
        .meta_value   (meta_value),
        .x_word       (x_word),
        .y_word       (y_word),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .frame_status (frame_status),
        .last_result  (last_result)
    );

endmodule

FILE: rtl/ppsp_front.sv
// ----------------------------------------------------------------------------
// ppsp_front: byte parser
// Walks the path records one byte per accepted beat, assembles metas and
// points, keeps the byte sum and writes one record per result-bearing byte.
// ----------------------------------------------------------------------------
module ppsp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              final_byte,
    input  logic [31:0]       expected_sum,
    output logic              rec_write,
    output ppsp_pkg::record_t rec
);
    import ppsp_pkg::*;

    typedef enum logic [2:0] {
        PH_FORMAT,
        PH_MCOUNT,
        PH_META,
        PH_PCOUNT,
        PH_POINTS
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  idx_reg, idx_next;
    logic [7:0]  fmt_reg, fmt_next;
    logic [7:0]  metas_left_reg, metas_left_next;
    logic [15:0] points_left_reg, points_left_next;
    logic [63:0] low_reg, low_next;
    logic [31:0] high_reg, high_next;
    logic [31:0] sum_reg, sum_next;
    logic        stopped_reg, stopped_next;
    logic [7:0]  code_words_reg;
    logic [7:0]  code_floats_reg;

    logic [63:0] put_low;
    logic [31:0] put_high;
    logic [3:0]  put_idx;
    logic [3:0]  point_need;
    logic        item_valid;
    kind_t       item_kind;
    logic        item_fmt;
    status_t     end_status;

    // byte placement into the assembly words
    always_comb
    begin
        put_low  = low_reg;
        put_high = high_reg;
        for (int i = 0; i < 8; i++)
        begin
            if (idx_reg == 4'(i))
                put_low[8*i +: 8] = data_byte;
        end
        for (int i = 0; i < 4; i++)
        begin
            if (idx_reg == 4'(i + 8))
                put_high[8*i +: 8] = data_byte;
        end
        put_idx    = idx_reg + 4'd1;
        point_need = (fmt_reg != 8'd0) ? 4'(FLOAT_POINT_BYTES) : 4'(WORD_POINT_BYTES);
    end

    // parse step
    always_comb
    begin
        phase_next       = phase_reg;
        idx_next         = idx_reg;
        fmt_next         = fmt_reg;
        metas_left_next  = metas_left_reg;
        points_left_next = points_left_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        stopped_next     = stopped_reg;
        sum_next         = sum_reg + 32'(data_byte);
        item_valid       = 1'b0;
        item_kind        = KIND_HEADER;
        item_fmt         = 1'b0;
        end_status       = STATUS_OK;

        if (!stopped_reg)
        begin
            case (phase_reg)
                PH_MCOUNT:
                begin
                    metas_left_next = data_byte;
                    idx_next        = 4'd0;
                    low_next        = 64'd0;
                    high_next       = 32'd0;
                    phase_next      = (data_byte != 8'd0) ? PH_META : PH_PCOUNT;
                end
                PH_META:
                begin
                    low_next  = put_low;
                    high_next = put_high;
                    idx_next  = put_idx;
                    if (put_idx >= 4'(META_BYTES))
                    begin
                        item_valid      = 1'b1;
                        item_kind       = KIND_META;
                        metas_left_next = metas_left_reg - 8'd1;
                        idx_next        = 4'd0;
                        low_next        = 64'd0;
                        high_next       = 32'd0;
                        if (metas_left_reg == 8'd1)
                            phase_next = PH_PCOUNT;
                    end
                end
                PH_PCOUNT:
                begin
                    low_next  = put_low;
                    high_next = put_high;
                    idx_next  = put_idx;
                    if (put_idx >= 4'(COUNT_BYTES))
                    begin
                        idx_next  = 4'd0;
                        low_next  = 64'd0;
                        high_next = 32'd0;
                        // words format wins when both codes match
                        if (fmt_reg == code_words_reg || fmt_reg == code_floats_reg)
                        begin
                            item_valid       = 1'b1;
                            item_kind        = KIND_HEADER;
                            item_fmt         = (fmt_reg != code_words_reg);
                            fmt_next         = {7'd0, item_fmt};
                            points_left_next = put_low[15:0];
                            phase_next       = (put_low[15:0] != 16'd0) ? PH_POINTS : PH_FORMAT;
                        end
                        else
                        begin
                            stopped_next = 1'b1;
                        end
                    end
                end
                PH_POINTS:
                begin
                    low_next  = put_low;
                    high_next = put_high;
                    idx_next  = put_idx;
                    if (put_idx >= point_need)
                    begin
                        item_valid       = 1'b1;
                        item_kind        = KIND_POINT;
                        item_fmt         = (fmt_reg != 8'd0);
                        points_left_next = points_left_reg - 16'd1;
                        idx_next         = 4'd0;
                        low_next         = 64'd0;
                        high_next        = 32'd0;
                        if (points_left_reg == 16'd1)
                            phase_next = PH_FORMAT;
                    end
                end
                default:
                begin
                    fmt_next   = data_byte;
                    phase_next = PH_MCOUNT;
                end
            endcase
        end

        // frame end: status, then back to the start of a frame
        if (final_byte)
        begin
            if (sum_next != expected_sum)
                end_status = STATUS_CHECKSUM;
            else if (stopped_next)
                end_status = STATUS_UNKNOWN;
            else if (phase_next != PH_FORMAT)
                end_status = STATUS_TRUNCATED;
            else
                end_status = STATUS_OK;
            phase_next       = PH_FORMAT;
            idx_next         = 4'd0;
            fmt_next         = 8'd0;
            metas_left_next  = 8'd0;
            points_left_next = 16'd0;
            low_next         = 64'd0;
            high_next        = 32'd0;
            sum_next         = 32'd0;
            stopped_next     = 1'b0;
        end
    end

    // record to the queue
    always_comb
    begin
        rec.item_valid = item_valid;
        rec.item_kind  = item_kind;
        rec.item_fmt   = item_fmt;
        rec.asm_low    = put_low;
        rec.asm_high   = put_high;
        rec.end_valid  = final_byte;
        rec.end_status = end_status;
        rec_write      = accept && (item_valid || final_byte);
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_FORMAT;
            idx_reg         <= 4'd0;
            fmt_reg         <= 8'd0;
            metas_left_reg  <= 8'd0;
            points_left_reg <= 16'd0;
            low_reg         <= 64'd0;
            high_reg        <= 32'd0;
            sum_reg         <= 32'd0;
            stopped_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            idx_reg         <= idx_next;
            fmt_reg         <= fmt_next;
            metas_left_reg  <= metas_left_next;
            points_left_reg <= points_left_next;
            low_reg         <= low_next;
            high_reg        <= high_next;
            sum_reg         <= sum_next;
            stopped_reg     <= stopped_next;
        end
    end

    // format code registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_words_reg  <= 8'd0;
            code_floats_reg <= 8'd1;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == REG_FORMAT_WORDS)
                code_words_reg <= cfg_data;
            else
                code_floats_reg <= cfg_data;
        end
    end

endmodule

FILE: rtl/ppsp_queue.sv
// ----------------------------------------------------------------------------
// ppsp_queue: record queue
// Small first-in first-out store between the parser and the result back end.
// ----------------------------------------------------------------------------
module ppsp_queue #(
    parameter int DEPTH = ppsp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  ppsp_pkg::record_t wr_data,
    input  logic              rd_en,
    output ppsp_pkg::record_t rd_data,
    output logic              full,
    output logic              empty
);
    import ppsp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    record_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_wr;
    logic               do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == CNT_W'(0));
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

FILE: rtl/ppsp_back.sv
// ----------------------------------------------------------------------------
// ppsp_back: result back end
// Holds one record, shows any item and then any frame end as result beats,
// and unpacks the assembly words into the result fields.
// ----------------------------------------------------------------------------
module ppsp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ppsp_pkg::record_t q_data,
    input  logic              q_empty,
    output logic              q_read,
    input  logic              pop,
    output logic              empty,
    output logic [1:0]        result_kind,
    output logic              path_format,
    output logic [15:0]       path_points,
    output logic [63:0]       meta_name,
    output logic [31:0]       meta_value,
    output logic [31:0]       x_word,
    output logic [31:0]       y_word,
    output logic [15:0]       red,
    output logic [15:0]       green,
    output logic [15:0]       blue,
    output logic [1:0]        frame_status,
    output logic              last_result
);
    import ppsp_pkg::*;

    record_t rec_reg;
    logic    valid_reg;
    logic    item_done_reg;
    logic    showing_end;
    logic    take;
    logic    finish;
    logic    load;

    // beat sequencing
    assign showing_end = !rec_reg.item_valid || item_done_reg;
    assign take        = valid_reg && pop;
    assign finish      = take && (showing_end || !rec_reg.end_valid);
    assign load        = (!valid_reg || finish) && !q_empty;
    assign q_read      = load;
    assign empty       = !valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            item_done_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg     <= 1'b1;
            item_done_reg <= 1'b0;
        end
        else if (finish)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            item_done_reg <= 1'b1;
        end
    end

    // held record
    always_ff @(posedge clk)
    begin
        if (load)
            rec_reg <= q_data;
    end

    // field unpacking
    always_comb
    begin
        result_kind  = showing_end ? KIND_END : rec_reg.item_kind;
        last_result  = showing_end || !rec_reg.end_valid;
        path_format  = 1'b0;
        path_points  = 16'd0;
        meta_name    = 64'd0;
        meta_value   = 32'd0;
        x_word       = 32'd0;
        y_word       = 32'd0;
        red          = 16'd0;
        green        = 16'd0;
        blue         = 16'd0;
        frame_status = 2'd0;
        if (showing_end)
        begin
            frame_status = rec_reg.end_status;
        end
        else
        begin
            case (rec_reg.item_kind)
                KIND_HEADER:
                begin
                    path_format = rec_reg.item_fmt;
                    path_points = rec_reg.asm_low[15:0];
                end
                KIND_META:
                begin
                    meta_name  = rec_reg.asm_low;
                    meta_value = rec_reg.asm_high;
                end
                KIND_POINT:
                begin
                    if (rec_reg.item_fmt)
                    begin
                        x_word = rec_reg.asm_low[31:0];
                        y_word = rec_reg.asm_low[63:32];
                        red    = {8'd0, rec_reg.asm_high[7:0]};
                        green  = {8'd0, rec_reg.asm_high[15:8]};
                        blue   = {8'd0, rec_reg.asm_high[23:16]};
                    end
                    else
                    begin
                        x_word = {16'd0, rec_reg.asm_low[15:0]};
                        y_word = {16'd0, rec_reg.asm_low[31:16]};
                        red    = rec_reg.asm_low[47:32];
                        green  = rec_reg.asm_low[63:48];
                        blue   = rec_reg.asm_high[15:0];
                    end
                end
                default:
                begin
                    frame_status = rec_reg.end_status;
                end
            endcase
        end
    end

endmodule

FILE: rtl/ppsp_checker.sv
// ----------------------------------------------------------------------------
// ppsp_checker: port-level checks
// Watches the top level's ports for result sequencing and queue behavior.
// ----------------------------------------------------------------------------
module ppsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  result_kind,
    input logic [1:0]  frame_status,
    input logic        last_result
);
    import ppsp_pkg::*;

    // a frame end beat always closes its byte
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == KIND_END) |-> last_result)
        else $error("frame end beat without last_result");

    // an item that is not last is followed by its frame end beat
    a_end_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && result_kind != KIND_END && !last_result)
        |=> (!empty && result_kind == KIND_END))
        else $error("missing frame end after non-last item");

    // status only rides on frame end beats
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind != KIND_END) |-> (frame_status == STATUS_OK))
        else $error("status set on a non-end beat");

    // full only rises after an accepted byte beat
    a_full_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose without an accepted byte");

endmodule

bind path_point_stream_parser_top ppsp_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .result_kind  (result_kind),
    .frame_status (frame_status),
    .last_result  (last_result)
);

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for path_point_stream_parser_top
// Feeds frame bytes through the push/full side and pops result beats from the
// empty/pop side. A behavioral parser in the bench tracks the record phase,
// the item assembly and the byte sum, and queues the beats each byte should
// produce. Every popped beat is compared field by field against the oldest
// queued beat. A short directed table is followed by random frames
// (well-formed, cut short, noise) across several format code settings and
// idle/stall patterns, including a long result-side hold and a full drain.
// ----------------------------------------------------------------------------
module tb;
    import ppsp_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int PHASE_ITEMS    = 125;
    localparam int NUM_PHASES     = 8;
    localparam int MAX_REPORTS    = 40;

    typedef enum logic [2:0] {
        PH_FORMAT,
        PH_MCOUNT,
        PH_META,
        PH_PCOUNT,
        PH_POINTS
    } parse_phase_t;

    typedef struct packed {
        kind_t       kind;
        logic        fmt;
        logic [15:0] points;
        logic [63:0] name;
        logic [31:0] value;
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        status_t     status;
        logic        last;
    } beat_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        fin;
        logic [31:0] esum;
        logic        typed;
        beat_t       want;
    } row_t;

    // DUT signals, all driven from time zero
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic        cfg_index    = REG_FORMAT_WORDS;
    logic [7:0]  cfg_data     = 8'd0;
    logic        push         = 1'b0;
    logic        full;
    logic [7:0]  data_byte    = 8'd0;
    logic        final_byte   = 1'b0;
    logic [31:0] expected_sum = 32'd0;
    logic        empty;
    logic        pop          = 1'b0;
    logic [1:0]  result_kind;
    logic        path_format;
    logic [15:0] path_points;
    logic [63:0] meta_name;
    logic [31:0] meta_value;
    logic [31:0] x_word;
    logic [31:0] y_word;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [1:0]  frame_status;
    logic        last_result;

    // typed expectation that travels with the byte on the bus
    logic  bus_typed = 1'b0;
    beat_t bus_want  = '0;

    // parser model state
    logic [7:0]   fmt_words_code  = 8'd0;
    logic [7:0]   fmt_floats_code = 8'd1;
    parse_phase_t pp_phase        = PH_FORMAT;
    logic [3:0]   asm_index       = 4'd0;
    logic [7:0]   pp_format       = 8'd0;
    logic [7:0]   pp_metas        = 8'd0;
    logic [15:0]  pp_points       = 16'd0;
    logic [63:0]  asm_lo          = 64'd0;
    logic [31:0]  asm_hi          = 32'd0;
    logic [31:0]  run_sum         = 32'd0;
    logic         pp_stopped      = 1'b0;

    beat_t      expected_beats[$];
    beat_t      byte_beats[$];
    row_t       directed_rows[$];
    logic [7:0] frame_q[$];

    int errors         = 0;
    int stall_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_done     = 0;
    int hold_left      = 0;

    path_point_stream_parser_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .final_byte   (final_byte),
        .expected_sum (expected_sum),
        .empty        (empty),
        .pop          (pop),
        .result_kind  (result_kind),
        .path_format  (path_format),
        .path_points  (path_points),
        .meta_name    (meta_name),
        .meta_value   (meta_value),
        .x_word       (x_word),
        .y_word       (y_word),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .frame_status (frame_status),
        .last_result  (last_result)
    );

    // clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // queue appends
    task automatic add_byte_beat(input beat_t bt);
        byte_beats.insert(byte_beats.size(), bt);
    endtask

    task automatic add_expected(input beat_t bt);
        expected_beats.insert(expected_beats.size(), bt);
    endtask

    task automatic add_frame_byte(input logic [7:0] b);
        frame_q.insert(frame_q.size(), b);
    endtask

    function automatic beat_t blank_beat(input kind_t k);
        beat_t bt;
        bt        = '0;
        bt.kind   = k;
        bt.status = STATUS_OK;
        return bt;
    endfunction

    // content byte biased toward the extremes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic clear_asm();
        asm_index = 4'd0;
        asm_lo    = 64'd0;
        asm_hi    = 32'd0;
    endtask

    task automatic put_asm(input logic [7:0] b);
        if (asm_index < 4'd8)
            asm_lo[8*asm_index +: 8] = b;
        else if (asm_index < 4'd12)
            asm_hi[8*(asm_index-8) +: 8] = b;
        asm_index = asm_index + 4'd1;
    endtask

    // parse one accepted byte, leaving its beats in byte_beats
    task automatic predict_byte(input logic [7:0] b, input logic fin, input logic [31:0] esum);
        beat_t       bt;
        logic [15:0] cnt;
        logic        ffmt;
        int          need;
        run_sum = run_sum + {24'd0, b};
        if (!pp_stopped)
        begin
            case (pp_phase)
                PH_MCOUNT:
                begin
                    pp_metas = b;
                    clear_asm();
                    pp_phase = (b != 8'd0) ? PH_META : PH_PCOUNT;
                end
                PH_META:
                begin
                    put_asm(b);
                    if (asm_index >= META_BYTES)
                    begin
                        bt       = blank_beat(KIND_META);
                        bt.name  = asm_lo;
                        bt.value = asm_hi;
                        add_byte_beat(bt);
                        pp_metas = pp_metas - 8'd1;
                        clear_asm();
                        if (pp_metas == 8'd0)
                            pp_phase = PH_PCOUNT;
                    end
                end
                PH_PCOUNT:
                begin
                    put_asm(b);
                    if (asm_index >= COUNT_BYTES)
                    begin
                        cnt = asm_lo[15:0];
                        if (pp_format == fmt_words_code || pp_format == fmt_floats_code)
                        begin
                            // words format wins when both codes match
                            ffmt      = (pp_format != fmt_words_code);
                            bt        = blank_beat(KIND_HEADER);
                            bt.fmt    = ffmt;
                            bt.points = cnt;
                            add_byte_beat(bt);
                            pp_format = {7'd0, ffmt};
                            pp_points = cnt;
                            clear_asm();
                            pp_phase  = (cnt != 16'd0) ? PH_POINTS : PH_FORMAT;
                        end
                        else
                        begin
                            // unknown format: rest of frame only adds to the sum
                            pp_stopped = 1'b1;
                            clear_asm();
                        end
                    end
                end
                PH_POINTS:
                begin
                    need = (pp_format != 8'd0) ? FLOAT_POINT_BYTES : WORD_POINT_BYTES;
                    put_asm(b);
                    if (asm_index >= need)
                    begin
                        bt = blank_beat(KIND_POINT);
                        if (pp_format != 8'd0)
                        begin
                            bt.x     = asm_lo[31:0];
                            bt.y     = asm_lo[63:32];
                            bt.red   = {8'd0, asm_hi[7:0]};
                            bt.green = {8'd0, asm_hi[15:8]};
                            bt.blue  = {8'd0, asm_hi[23:16]};
                        end
                        else
                        begin
                            bt.x     = {16'd0, asm_lo[15:0]};
                            bt.y     = {16'd0, asm_lo[31:16]};
                            bt.red   = asm_lo[47:32];
                            bt.green = asm_lo[63:48];
                            bt.blue  = asm_hi[15:0];
                        end
                        add_byte_beat(bt);
                        pp_points = pp_points - 16'd1;
                        clear_asm();
                        if (pp_points == 16'd0)
                            pp_phase = PH_FORMAT;
                    end
                end
                default:
                begin
                    pp_format = b;
                    pp_phase  = PH_MCOUNT;
                end
            endcase
        end

        // frame end: status priority checksum, unknown, truncated
        if (fin)
        begin
            bt = blank_beat(KIND_END);
            if (run_sum != esum)
                bt.status = STATUS_CHECKSUM;
            else if (pp_stopped)
                bt.status = STATUS_UNKNOWN;
            else if (pp_phase != PH_FORMAT)
                bt.status = STATUS_TRUNCATED;
            else
                bt.status = STATUS_OK;
            add_byte_beat(bt);
            pp_phase   = PH_FORMAT;
            pp_format  = 8'd0;
            pp_metas   = 8'd0;
            pp_points  = 16'd0;
            run_sum    = 32'd0;
            pp_stopped = 1'b0;
            clear_asm();
        end

        if (byte_beats.size() != 0)
        begin
            bt      = byte_beats.pop_back();
            bt.last = 1'b1;
            add_byte_beat(bt);
        end
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors = errors + 1;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    // result checking, model updates and watchdog
    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_beats.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result beat expected none actual kind %0d",
                                 $time, result_kind);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    check_field("result_kind", 64'(want.kind), 64'(result_kind));
                    check_field("path_format", 64'(want.fmt), 64'(path_format));
                    check_field("path_points", 64'(want.points), 64'(path_points));
                    check_field("meta_name", want.name, meta_name);
                    check_field("meta_value", 64'(want.value), 64'(meta_value));
                    check_field("x_word", 64'(want.x), 64'(x_word));
                    check_field("y_word", 64'(want.y), 64'(y_word));
                    check_field("red", 64'(want.red), 64'(red));
                    check_field("green", 64'(want.green), 64'(green));
                    check_field("blue", 64'(want.blue), 64'(blue));
                    check_field("frame_status", 64'(want.status), 64'(frame_status));
                    check_field("last_result", 64'(want.last), 64'(last_result));
                end
            end

            if (cfg_write_en)
            begin
                if (cfg_index == REG_FORMAT_WORDS)
                    fmt_words_code = cfg_data;
                else
                    fmt_floats_code = cfg_data;
            end

            if (push && !full)
            begin
                byte_beats.delete();
                predict_byte(data_byte, final_byte, expected_sum);
                if (bus_typed)
                    add_expected(bus_want);
                else
                    foreach (byte_beats[k])
                        add_expected(byte_beats[k]);
            end

            if ((pop && !empty) || (push && !full))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("path_point_stream_parser_top: mismatch");
                $finish;
            end
        end
    end

    // result side: random stalls plus an occasional long hold
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_done != hold_requests)
        begin
            pop        <= 1'b0;
            holds_done <= holds_done + 1;
            hold_left  <= HOLD_CYCLES;
        end
        else
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // offer one byte beat and wait until it is taken
    task automatic send_beat(input logic [7:0] b, input logic fin, input logic [31:0] esum,
                             input logic typed, input beat_t want);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        data_byte    <= b;
        final_byte   <= fin;
        expected_sum <= esum;
        bus_typed    <= typed;
        bus_want     <= want;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // stop sending and let every expected beat arrive
    task automatic wait_results_drained();
        push <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_formats(input logic [7:0] words_code, input logic [7:0] floats_code);
        wait_results_drained();
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_FORMAT_WORDS;
        cfg_data     <= words_code;
        @(posedge clk);
        cfg_index    <= REG_FORMAT_FLOATS;
        cfg_data     <= floats_code;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic add_row(input logic [7:0] b, input logic fin, input logic [31:0] esum,
                           input logic typed, input status_t st);
        row_t rw;
        rw.data        = b;
        rw.fin         = fin;
        rw.esum        = esum;
        rw.typed       = typed;
        rw.want        = blank_beat(KIND_END);
        rw.want.status = st;
        rw.want.last   = 1'b1;
        directed_rows.insert(directed_rows.size(), rw);
    endtask

    // stimulus
    initial
    begin
        int          p;
        int          sel;
        int          sent;
        int          n;
        int          metas;
        int          pts;
        int          need;
        int          keep;
        logic [7:0]  fb;
        logic [31:0] sum;
        logic [31:0] esum;
        logic        held;
        logic        paused;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset codes (words 0, floats 1)
        // lone format byte ending the frame: truncated
        add_row(8'h00, 1'b1, 32'd0, 1'b1, STATUS_TRUNCATED);
        // sum off
        add_row(8'hFF, 1'b1, 32'd0, 1'b1, STATUS_CHECKSUM);
        add_row(8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1, STATUS_CHECKSUM);
        // unknown format code, no metas, zero points
        add_row(8'h07, 1'b0, 32'd0, 1'b0, STATUS_OK);
        add_row(8'h00, 1'b0, 32'd0, 1'b0, STATUS_OK);
        add_row(8'h00, 1'b0, 32'd0, 1'b0, STATUS_OK);
        add_row(8'h00, 1'b1, 32'd7, 1'b1, STATUS_UNKNOWN);
        // float path, one all-ones meta, zero points, final on the count byte
        add_row(8'h01, 1'b0, 32'd0, 1'b0, STATUS_OK);
        add_row(8'h01, 1'b0, 32'd0, 1'b0, STATUS_OK);
        repeat (META_BYTES) add_row(8'hFF, 1'b0, 32'hFFFF_FFFF, 1'b0, STATUS_OK);
        add_row(8'h00, 1'b0, 32'd0, 1'b0, STATUS_OK);
        add_row(8'h00, 1'b1, 32'd3062, 1'b0, STATUS_OK);
        foreach (directed_rows[k])
            send_beat(directed_rows[k].data, directed_rows[k].fin, directed_rows[k].esum,
                      directed_rows[k].typed, directed_rows[k].want);

        // random frames over several code settings and pacing patterns
        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       write_formats(8'd0, 8'd1);
                1:       write_formats(8'd255, 8'd0);
                2:       write_formats(8'd0, 8'd255);
                3:       write_formats(8'd9, 8'd9);
                4:       write_formats(8'd128, 8'd127);
                5:       write_formats(8'd1, 8'd0);
                default: write_formats(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1:       begin send_idle_pct = 70; recv_stall_pct <= 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct <= 70; end
                default: begin send_idle_pct = 22; recv_stall_pct <= 22; end
            endcase
            sent   = 0;
            held   = 1'b0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS)
            begin
                // long result-side hold while bytes keep coming
                if (p == 0 && !held)
                begin
                    hold_requests <= hold_requests + 1;
                    held = 1'b1;
                end
                // sender pause until all results are out
                if (p == 4 && !paused && sent != 0)
                begin
                    wait_results_drained();
                    paused = 1'b1;
                end

                frame_q.delete();
                sel = $urandom_range(0, 19);
                if (sel >= 17)
                begin
                    // noise
                    n = $urandom_range(1, 24);
                    repeat (n) add_frame_byte(8'($urandom_range(0, 255)));
                end
                else
                begin
                    n = $urandom_range(1, 3);
                    repeat (n)
                    begin
                        sel = $urandom_range(0, 9);
                        if (sel < 5)
                            fb = fmt_words_code;
                        else if (sel < 9)
                            fb = fmt_floats_code;
                        else
                            fb = 8'($urandom_range(0, 255));
                        add_frame_byte(fb);
                        sel = $urandom_range(0, 9);
                        if (sel < 4)
                            metas = 0;
                        else if (sel < 8)
                            metas = $urandom_range(1, 3);
                        else
                            metas = $urandom_range(4, 6);
                        add_frame_byte(8'(metas));
                        repeat (metas * META_BYTES) add_frame_byte(pick_byte());
                        sel = $urandom_range(0, 9);
                        if (sel < 2)
                            pts = 0;
                        else if (sel < 9)
                            pts = $urandom_range(1, 4);
                        else
                            pts = $urandom_range(5, 40);
                        add_frame_byte(8'(pts));
                        add_frame_byte(8'(pts >> 8));
                        if (fb != fmt_words_code && fb == fmt_floats_code)
                            need = FLOAT_POINT_BYTES;
                        else
                            need = WORD_POINT_BYTES;
                        repeat (pts * need) add_frame_byte(pick_byte());
                    end
                    // some frames cut short
                    if ($urandom_range(0, 16) >= 15)
                    begin
                        keep = $urandom_range(1, frame_q.size());
                        while (frame_q.size() > keep)
                            void'(frame_q.pop_back());
                    end
                end

                sum = 32'd0;
                foreach (frame_q[k])
                    sum = sum + {24'd0, frame_q[k]};
                esum = ($urandom_range(0, 9) == 0) ? $urandom() : sum;
                foreach (frame_q[k])
                begin
                    if (k == frame_q.size() - 1)
                        send_beat(frame_q[k], 1'b1, esum, 1'b0, blank_beat(KIND_END));
                    else
                        send_beat(frame_q[k], 1'b0, $urandom(), 1'b0, blank_beat(KIND_END));
                end
                sent = sent + frame_q.size();
            end
        end

        wait_results_drained();
        if (errors == 0)
            $display("path_point_stream_parser_top: match");
        else
            $display("path_point_stream_parser_top: mismatch");
        $finish;
    end

endmodule
